FILE: design/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// lsbse_pkg
// Shared types and constants for the red-channel LSB embed/extract block.
// ----------------------------------------------------------------------------
package lsbse_pkg;

    // Fixed field widths
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned POS_W     = 33;
    localparam int unsigned HDR_IDX_W = 5;   // covers a header of up to 32 bits
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 32;

    // Default header length
    localparam int unsigned HEADER_BITS_DEF = 32;

    // Depth of the queue between front and back
    localparam int unsigned Q_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_BITS = 1'd1;

    // Operating mode
    typedef enum logic
    {
        MODE_EMBED   = 1'b0,
        MODE_EXTRACT = 1'b1
    } mode_t;

    // Classified pixel handed from front to back
    typedef struct packed
    {
        logic                sof;        // clear back-end shift state first
        mode_t               mode;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic [CHAN_W-1:0]   msg;
        logic                hdr;        // pixel lies in the length header
        logic [HDR_IDX_W-1:0] hdr_idx;   // header bit number
        logic                hdr_bit;    // embed: header bit to write
        logic                hdr_done;   // all header bits read after this pixel
        logic [POS_W-1:0]    offset;     // position past the header
        logic                emb_active; // embed: pixel carries a message bit
    } cls_t;

endpackage

FILE: design/lsbse_front.sv
// ----------------------------------------------------------------------------
// lsbse_front
// Accepts pixels, tracks the position counter and classifies each pixel.
// ----------------------------------------------------------------------------
module lsbse_front #(
    parameter int unsigned HEADER_BITS = lsbse_pkg::HEADER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              start_of_image,
    input  logic [lsbse_pkg::CHAN_W-1:0]      red_in,
    input  logic [lsbse_pkg::CHAN_W-1:0]      green_in,
    input  logic [lsbse_pkg::CHAN_W-1:0]      blue_in,
    input  logic [lsbse_pkg::CHAN_W-1:0]      message_byte,
    input  lsbse_pkg::mode_t                  mode,
    input  logic [lsbse_pkg::LEN_W-1:0]       payload_bits,
    output lsbse_pkg::cls_t                   cls
);
    import lsbse_pkg::*;

    localparam logic [POS_W-1:0] HB_POS   = POS_W'(HEADER_BITS);
    localparam logic [POS_W-1:0] HB_LAST  = POS_W'(HEADER_BITS - 1);
    localparam logic [POS_W-1:0] POS_SAT  = {POS_W{1'b1}};

    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic [POS_W-1:0] pos_cur;
    logic [LEN_W-1:0] len;

    // Header-limited payload length
    always_comb
    begin
        for (int i = 0; i < LEN_W; i++)
        begin
            len[i] = payload_bits[i] & (i < HEADER_BITS);
        end
    end

    // Position of this pixel and saturating advance
    assign pos_cur       = start_of_image ? '0 : position_reg;
    assign position_next = (pos_cur == POS_SAT) ? pos_cur : pos_cur + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
        end
        else if (push)
        begin
            position_reg <= position_next;
        end
    end

    // Classification
    always_comb
    begin
        cls            = '0;
        cls.sof        = start_of_image;
        cls.mode       = mode;
        cls.red        = red_in;
        cls.green      = green_in;
        cls.blue       = blue_in;
        cls.msg        = message_byte;
        cls.hdr        = (pos_cur < HB_POS);
        cls.hdr_idx    = pos_cur[HDR_IDX_W-1:0];
        cls.hdr_bit    = len[pos_cur[HDR_IDX_W-1:0]];
        cls.hdr_done   = (pos_cur >= HB_LAST);
        cls.offset     = pos_cur - HB_POS;
        cls.emb_active = (cls.offset < {1'b0, len});
    end

endmodule

FILE: design/lsbse_queue.sv
// ----------------------------------------------------------------------------
// lsbse_queue
// Short FIFO of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module lsbse_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lsbse_pkg::cls_t   push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output lsbse_pkg::cls_t   pop_data
);
    import lsbse_pkg::*;

    localparam int unsigned PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

    cls_t             entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/lsbse_back.sv
// ----------------------------------------------------------------------------
// lsbse_back
// Embeds or extracts message bits and holds the result register.
// ----------------------------------------------------------------------------
module lsbse_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_not_empty,
    input  lsbse_pkg::cls_t                   q_data,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lsbse_pkg::CHAN_W-1:0]      red_out,
    output logic [lsbse_pkg::CHAN_W-1:0]      green_out,
    output logic [lsbse_pkg::CHAN_W-1:0]      blue_out,
    output logic                              byte_taken,
    output logic [lsbse_pkg::CHAN_W-1:0]      text_byte,
    output logic                              text_byte_valid,
    output logic [lsbse_pkg::LEN_W-1:0]       decoded_length,
    output logic                              length_valid
);
    import lsbse_pkg::*;

    logic [LEN_W-1:0]  length_shift_reg;
    logic [LEN_W-1:0]  length_shift_next;
    logic [CHAN_W-1:0] byte_shift_reg;
    logic [CHAN_W-1:0] byte_shift_next;
    logic [CHAN_W-1:0] byte_asm_reg;
    logic [CHAN_W-1:0] byte_asm_next;
    logic              out_valid_reg;

    logic [CHAN_W-1:0] red_next;
    logic              taken_next;
    logic [CHAN_W-1:0] tbyte_next;
    logic              tvalid_next;
    logic [LEN_W-1:0]  dlen_next;
    logic              lvalid_next;

    logic [LEN_W-1:0]  ls_cur;
    logic [CHAN_W-1:0] bs_cur;
    logic [CHAN_W-1:0] ba_cur;
    logic [CHAN_W-1:0] bs_load;
    logic [CHAN_W-1:0] ba_acc;
    logic [2:0]        bit_idx;
    logic              red_bit;

    // Take the next transaction when the result register frees up
    assign q_pop     = q_not_empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    // Per-pixel embed / extract step
    always_comb
    begin
        ls_cur  = q_data.sof ? '0 : length_shift_reg;
        bs_cur  = q_data.sof ? '0 : byte_shift_reg;
        ba_cur  = q_data.sof ? '0 : byte_asm_reg;
        bit_idx = q_data.offset[2:0];
        red_bit = q_data.red[0];
        bs_load = bs_cur;
        ba_acc  = ba_cur;

        length_shift_next = ls_cur;
        byte_shift_next   = bs_cur;
        byte_asm_next     = ba_cur;
        red_next          = q_data.red;
        taken_next        = 1'b0;
        tbyte_next        = '0;
        tvalid_next       = 1'b0;
        dlen_next         = '0;
        lvalid_next       = 1'b0;

        if (q_data.mode == MODE_EMBED)
        begin
            if (q_data.hdr)
            begin
                red_next = {q_data.red[CHAN_W-1:1], q_data.hdr_bit};
            end
            else if (q_data.emb_active)
            begin
                if (bit_idx == 3'd0)
                begin
                    bs_load    = q_data.msg;
                    taken_next = 1'b1;
                end
                red_next        = {q_data.red[CHAN_W-1:1], bs_load[0]};
                byte_shift_next = {1'b0, bs_load[CHAN_W-1:1]};
            end
        end
        else
        begin
            if (q_data.hdr)
            begin
                length_shift_next = ls_cur | (LEN_W'(red_bit) << q_data.hdr_idx);
            end
            else if (q_data.offset < {1'b0, ls_cur})
            begin
                if (bit_idx == 3'd0)
                begin
                    ba_acc = '0;
                end
                ba_acc        = ba_acc | (CHAN_W'(red_bit) << bit_idx);
                byte_asm_next = ba_acc;
                if (bit_idx == 3'd7)
                begin
                    tbyte_next    = ba_acc;
                    tvalid_next   = 1'b1;
                    byte_asm_next = '0;
                end
            end
            if (q_data.hdr_done)
            begin
                lvalid_next = 1'b1;
                dlen_next   = length_shift_next;
            end
        end
    end

    // Shift state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_shift_reg <= '0;
            byte_shift_reg   <= '0;
            byte_asm_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                length_shift_reg <= length_shift_next;
                byte_shift_reg   <= byte_shift_next;
                byte_asm_reg     <= byte_asm_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            red_out         <= red_next;
            green_out       <= q_data.green;
            blue_out        <= q_data.blue;
            byte_taken      <= taken_next;
            text_byte       <= tbyte_next;
            text_byte_valid <= tvalid_next;
            decoded_length  <= dlen_next;
            length_valid    <= lvalid_next;
        end
    end

endmodule

FILE: design/lsb_stego_embed_extract.sv
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract
// LSB steganography in the red channel with a length header: embeds a
// message into a pixel stream or extracts it again.
// ----------------------------------------------------------------------------
// Path: a pixel is classified by the combinational front, registered into the
// queue, then the back step writes it into the output register.
// Throughput: one pixel per clock; the two-entry queue stalls the input only
// when the output side is stalled.
// Reset: position counter and shift state cleared, mode embed, length zero.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract #(
    parameter int unsigned HEADER_BITS = lsbse_pkg::HEADER_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [lsbse_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsbse_pkg::CFG_DAT_W-1:0]    cfg_data,
    // pixel input
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               start_of_image,
    input  logic [lsbse_pkg::CHAN_W-1:0]       red_in,
    input  logic [lsbse_pkg::CHAN_W-1:0]       green_in,
    input  logic [lsbse_pkg::CHAN_W-1:0]       blue_in,
    input  logic [lsbse_pkg::CHAN_W-1:0]       message_byte,
    // result output
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lsbse_pkg::CHAN_W-1:0]       red_out,
    output logic [lsbse_pkg::CHAN_W-1:0]       green_out,
    output logic [lsbse_pkg::CHAN_W-1:0]       blue_out,
    output logic                               byte_taken,
    output logic [lsbse_pkg::CHAN_W-1:0]       text_byte,
    output logic                               text_byte_valid,
    output logic [lsbse_pkg::LEN_W-1:0]        decoded_length,
    output logic                               length_valid
);
    import lsbse_pkg::*;

    mode_t            mode_reg;
    logic [LEN_W-1:0] payload_bits_reg;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_not_empty;
    cls_t             front_cls;
    cls_t             q_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_EMBED;
            payload_bits_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:         mode_reg         <= mode_t'(cfg_data[0]);
                REG_PAYLOAD_BITS: payload_bits_reg <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input handshake
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    lsbse_front #(
        .HEADER_BITS (HEADER_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (q_push),
        .start_of_image (start_of_image),
        .red_in         (red_in),
        .green_in       (green_in),
        .blue_in        (blue_in),
        .message_byte   (message_byte),
        .mode           (mode_reg),
        .payload_bits   (payload_bits_reg),
        .cls            (front_cls)
    );

    lsbse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_cls),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    lsbse_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_data          (q_data),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .red_out         (red_out),
        .green_out       (green_out),
        .blue_out        (blue_out),
        .byte_taken      (byte_taken),
        .text_byte       (text_byte),
        .text_byte_valid (text_byte_valid),
        .decoded_length  (decoded_length),
        .length_valid    (length_valid)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the red-channel LSB embed/extract block.
// A local predictor tracks the pixel position, the header and byte shift
// state, and works out every output field for each accepted pixel. Results
// are checked in order against that prediction while both handshake sides
// idle and stall at random. Stimulus is built from whole images (header
// pixels and payload pixels), with some broken images mixed in.
// ----------------------------------------------------------------------------
module tb;
    import lsbse_pkg::*;

    localparam int unsigned HDR_BITS       = HEADER_BITS_DEF;
    localparam int unsigned ITEM_TARGET    = 1200;
    localparam int unsigned IDLE_PCT       = 19;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned HOLD_CYCLES    = 64;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PRINT_LIMIT    = 40;

    // One incoming pixel transaction
    typedef struct packed
    {
        logic              sof;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] msg;
    } pixel_in_t;

    // One result transaction
    typedef struct packed
    {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              taken;
        logic [CHAN_W-1:0] tbyte;
        logic              tvalid;
        logic [LEN_W-1:0]  dlen;
        logic              lvalid;
    } pixel_res_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 start_of_image;
    logic [CHAN_W-1:0]    red_in;
    logic [CHAN_W-1:0]    green_in;
    logic [CHAN_W-1:0]    blue_in;
    logic [CHAN_W-1:0]    message_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic [CHAN_W-1:0]    red_out;
    logic [CHAN_W-1:0]    green_out;
    logic [CHAN_W-1:0]    blue_out;
    logic                 byte_taken;
    logic [CHAN_W-1:0]    text_byte;
    logic                 text_byte_valid;
    logic [LEN_W-1:0]     decoded_length;
    logic                 length_valid;

    // Predictor state and its copy of the registers
    mode_t             cur_mode;
    logic [LEN_W-1:0]  cur_payload_bits;
    logic [POS_W-1:0]  pix_pos;
    logic [LEN_W-1:0]  hdr_acc;
    logic [CHAN_W-1:0] emb_byte;
    logic [CHAN_W-1:0] ext_byte;

    pixel_res_t  expected_pixels[$];
    pixel_res_t  oldest_pixel;
    int unsigned err_count;
    int unsigned sent_count;
    int unsigned result_count;
    int unsigned hold_len;
    int unsigned quiet_cycles;
    bit          no_idle;

    lsb_stego_embed_extract u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .start_of_image  (start_of_image),
        .red_in          (red_in),
        .green_in        (green_in),
        .blue_in         (blue_in),
        .message_byte    (message_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .red_out         (red_out),
        .green_out       (green_out),
        .blue_out        (blue_out),
        .byte_taken      (byte_taken),
        .text_byte       (text_byte),
        .text_byte_valid (text_byte_valid),
        .decoded_length  (decoded_length),
        .length_valid    (length_valid)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Expected result of one pixel; advances the predictor state
    function automatic pixel_res_t predict_stego_pixel(pixel_in_t px);
        pixel_res_t       r;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] off;
        logic             bitv;
        logic [2:0]       j;
        r       = '0;
        r.red   = px.red;
        r.green = px.green;
        r.blue  = px.blue;
        if (px.sof)
        begin
            pix_pos  = '0;
            hdr_acc  = '0;
            emb_byte = '0;
            ext_byte = '0;
        end
        p   = pix_pos;
        off = p - POS_W'(HDR_BITS);
        if (cur_mode == MODE_EMBED)
        begin
            // header bits first, then message bits, then pass-through
            if (p < POS_W'(HDR_BITS))
                r.red[0] = cur_payload_bits[p[4:0]];
            else if (off < {1'b0, cur_payload_bits})
            begin
                if (off[2:0] == 3'd0)
                begin
                    emb_byte = px.msg;
                    r.taken  = 1'b1;
                end
                r.red[0] = emb_byte[0];
                emb_byte = emb_byte >> 1;
            end
        end
        else
        begin
            bitv = px.red[0];
            if (p < POS_W'(HDR_BITS))
                hdr_acc = hdr_acc | (LEN_W'(bitv) << p[4:0]);
            else if (off < {1'b0, hdr_acc})
            begin
                j = off[2:0];
                if (j == 3'd0)
                    ext_byte = '0;
                ext_byte[j] = ext_byte[j] | bitv;
                if (j == 3'd7)
                begin
                    r.tbyte  = ext_byte;
                    r.tvalid = 1'b1;
                    ext_byte = '0;
                end
            end
            if (({1'b0, p} + 34'd1) >= 34'(HDR_BITS))
            begin
                r.lvalid = 1'b1;
                r.dlen   = hdr_acc;
            end
        end
        // saturating position counter
        if (pix_pos != '1)
            pix_pos = pix_pos + 1'b1;
        return r;
    endfunction

    function automatic pixel_in_t mk_pixel(logic sof, logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b, logic [7:0] m);
        pixel_in_t px;
        px.sof   = sof;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        px.msg   = m;
        return px;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("MISMATCH result %0d %0s: got 0x%0h, expected 0x%0h",
                     result_count, what, got, want);
    endtask

    // Result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected result", 32'd0, 32'd0);
            else
            begin
                oldest_pixel = expected_pixels.pop_front();
                if (red_out !== oldest_pixel.red)
                    report_mismatch("red_out", red_out, oldest_pixel.red);
                if (green_out !== oldest_pixel.green)
                    report_mismatch("green_out", green_out, oldest_pixel.green);
                if (blue_out !== oldest_pixel.blue)
                    report_mismatch("blue_out", blue_out, oldest_pixel.blue);
                if (byte_taken !== oldest_pixel.taken)
                    report_mismatch("byte_taken", byte_taken, oldest_pixel.taken);
                if (text_byte !== oldest_pixel.tbyte)
                    report_mismatch("text_byte", text_byte, oldest_pixel.tbyte);
                if (text_byte_valid !== oldest_pixel.tvalid)
                    report_mismatch("text_byte_valid", text_byte_valid,
                                    oldest_pixel.tvalid);
                if (decoded_length !== oldest_pixel.dlen)
                    report_mismatch("decoded_length", decoded_length, oldest_pixel.dlen);
                if (length_valid !== oldest_pixel.lvalid)
                    report_mismatch("length_valid", length_valid, oldest_pixel.lvalid);
            end
            result_count++;
        end
    end

    // Receiver: random stalls, forced hold-off, or none at all
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                out_stall = 1'b1;
                hold_len--;
            end
            else if (no_idle)
                out_stall = 1'b0;
            else
                out_stall = ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: ends the run after too long without any transaction
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
                break;
        end
        $display("TIMEOUT after %0d quiet cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
    end

    // Offer one pixel and wait for it to be taken
    task automatic send_pixel(input pixel_in_t px);
        pixel_res_t exp_res;
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        start_of_image = px.sof;
        red_in         = px.red;
        green_in       = px.green;
        blue_in        = px.blue;
        message_byte   = px.msg;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        exp_res         = predict_stego_pixel(px);
        expected_pixels = {expected_pixels, exp_res};
        sent_count++;
    endtask

    // Stop offering and wait until every expected result has come
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_MODE)
            cur_mode = mode_t'(val[0]);
        else if (idx == REG_PAYLOAD_BITS)
            cur_payload_bits = val;
    endtask

    // A run of pixels; optionally a well-formed header and stray image starts
    task automatic send_image(input int unsigned n, input logic [31:0] hdr_val,
                              input bit form_hdr, input bit with_sof, input bit noisy);
        pixel_in_t px;
        for (int unsigned i = 0; i < n; i++)
        begin
            px = mk_pixel(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            if (i == 0)
                px.sof = with_sof && !(noisy && $urandom_range(3) == 0);
            else
                px.sof = noisy && ($urandom_range(19) == 0);
            if (form_hdr && i < HDR_BITS)
                px.red[0] = hdr_val[i];
            send_pixel(px);
        end
    endtask

    function automatic int unsigned image_len(input logic [31:0] bits,
                                              input int unsigned cap);
        return HDR_BITS + ((bits > cap) ? cap : bits) + $urandom_range(0, 8);
    endfunction

    // Field extremes, reset register values, both modes
    task automatic test_field_extremes();
        send_pixel(mk_pixel(1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(mk_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(mk_pixel(1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00));
        send_pixel(mk_pixel(1'b0, 8'h01, 8'hFF, 8'h00, 8'hFF));
        write_reg(REG_PAYLOAD_BITS, 32'hFFFF_FFFF);
        send_pixel(mk_pixel(1'b1, 8'h00, 8'h5A, 8'hA5, 8'h00));
        send_pixel(mk_pixel(1'b0, 8'hFE, 8'hA5, 8'h5A, 8'hFF));
        send_pixel(mk_pixel(1'b0, 8'hFF, 8'hFF, 8'h00, 8'h80));
        write_reg(REG_MODE, MODE_EXTRACT);
        send_pixel(mk_pixel(1'b1, 8'hFF, 8'h00, 8'h00, 8'hFF));
        send_pixel(mk_pixel(1'b0, 8'h00, 8'hFF, 8'hFF, 8'h00));
        send_pixel(mk_pixel(1'b0, 8'h01, 8'h80, 8'h7F, 8'h01));
        send_pixel(mk_pixel(1'b1, 8'hFE, 8'h7F, 8'h80, 8'hFE));
        write_reg(REG_PAYLOAD_BITS, 32'd0);
        write_reg(REG_MODE, MODE_EMBED);
    endtask

    // Whole embed images over payload lengths around byte boundaries
    task automatic test_embed_images();
        logic [31:0] lens[7];
        lens = '{32'd0, 32'd1, 32'd7, 32'd8, 32'd9, 32'd24, 32'hFFFF_FFFF};
        no_idle = 1'b1;
        foreach (lens[k])
        begin
            if (k == 4)
                no_idle = 1'b0;
            write_reg(REG_PAYLOAD_BITS, lens[k]);
            send_image(image_len(lens[k], 48), 32'd0, 1'b0, 1'b1, 1'b0);
        end
    endtask

    // Extract images: partial trailing byte, unsigned length, huge length
    task automatic test_extract_images();
        logic [31:0] hdrs[6];
        hdrs = '{32'd0, 32'd5, 32'd8, 32'd21, 32'h8000_0000, 32'hFFFF_FFFF};
        write_reg(REG_MODE, MODE_EXTRACT);
        foreach (hdrs[k])
            send_image(image_len(hdrs[k], 48), hdrs[k], 1'b1, 1'b1, 1'b0);
    endtask

    // Mode and length changes in the middle of an image
    task automatic test_mode_switch();
        write_reg(REG_MODE, MODE_EMBED);
        write_reg(REG_PAYLOAD_BITS, 32'd16);
        send_image(20, 32'd0, 1'b0, 1'b1, 1'b0);
        write_reg(REG_MODE, MODE_EXTRACT);
        send_image(30, 32'd0, 1'b0, 1'b0, 1'b0);
        write_reg(REG_MODE, MODE_EMBED);
        send_image(20, 32'd0, 1'b0, 1'b0, 1'b0);
        write_reg(REG_PAYLOAD_BITS, 32'd64);
        send_image(40, 32'd0, 1'b0, 1'b0, 1'b0);
    endtask

    // Receiver holds off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        write_reg(REG_MODE, MODE_EXTRACT);
        send_image(10, 32'd40, 1'b1, 1'b1, 1'b0);
        hold_len = HOLD_CYCLES;
        send_image(70, 32'd0, 1'b0, 1'b0, 1'b0);
        wait_idle();
        write_reg(REG_MODE, MODE_EMBED);
        write_reg(REG_PAYLOAD_BITS, 32'd40);
        hold_len = HOLD_CYCLES;
        send_image(80, 32'd0, 1'b0, 1'b1, 1'b0);
        wait_idle();
    endtask

    // Random settings, mostly well-formed images, some broken ones
    task automatic test_random_mix();
        logic [31:0] len;
        bit          noisy;
        int unsigned sel;
        while (sent_count < ITEM_TARGET)
        begin
            sel = $urandom_range(9);
            if (sel <= 6)
                len = $urandom_range(0, 64);
            else if (sel == 7)
                len = 32'd0;
            else if (sel == 8)
                len = 32'hFFFF_FFFF;
            else
                len = $urandom;
            write_reg(REG_MODE, $urandom_range(1));
            write_reg(REG_PAYLOAD_BITS, len);
            repeat ($urandom_range(1, 3))
            begin
                noisy = ($urandom_range(4) == 0);
                if (noisy)
                    send_image($urandom_range(1, 60), len, 1'b0, 1'b1, 1'b1);
                else
                    send_image(image_len(len, 64), len, 1'b1, 1'b1, 1'b0);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_MODE;
        cfg_data         = '0;
        in_valid         = 1'b0;
        start_of_image   = 1'b0;
        red_in           = '0;
        green_in         = '0;
        blue_in          = '0;
        message_byte     = '0;
        cur_mode         = MODE_EMBED;
        cur_payload_bits = '0;
        pix_pos          = '0;
        hdr_acc          = '0;
        emb_byte         = '0;
        ext_byte         = '0;
        err_count        = 0;
        sent_count       = 0;
        result_count     = 0;
        hold_len         = 0;
        no_idle          = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_field_extremes();
        test_embed_images();
        test_extract_images();
        test_mode_switch();
        test_backpressure();
        test_random_mix();

        // drain, then give any stray result time to appear
        wait_idle();
        repeat (6) @(posedge clk);
        if (err_count == 0 && expected_pixels.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: lsb_stego_embed_extract.f
design/lsbse_pkg.sv
design/lsbse_front.sv
design/lsbse_queue.sv
design/lsbse_back.sv
design/lsb_stego_embed_extract.sv
tb/tb.sv
